// File: src/rmrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmrt_pkg
// Shared field widths, event kind codes and the controller/datapath
// command and status bundles of the rate-monotonic ready table.
// ----------------------------------------------------------------------------
package rmrt_pkg;

	localparam int KIND_W  = 2;
	localparam int TASK_W  = 5;
	localparam int TIME_W  = 16;
	localparam int COUNT_W = 16;

	// Task ids at or above this bound are ignored.
	localparam int MAX_TASKS = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_RELEASE  = 2'd0,
		KIND_EXPIRE   = 2'd1,
		KIND_RUN      = 2'd2,
		KIND_COMPLETE = 2'd3
	} kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // latch the event, restart the sweep
		logic step;    // process one table entry
		logic finish;  // append if needed, publish the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;  // every occupied entry has been visited
	} stat_t;

endpackage
`default_nettype wire

// File: src/rate_monotonic_ready_table.sv
// Flow: an accepted event starts a sweep over the jobs already in the table (at most
//   TABLE_DEPTH); the result is published once the sweep ends and the result register is free.
// The sweep reads one table entry per cycle. A new event is accepted only after the
//   previous one is published. A waiting result does not block acceptance of the next event.
// Reset: arst_n clears the table (empty), both counters and the result register.
`default_nettype none
// ----------------------------------------------------------------------------
// rate_monotonic_ready_table
// Rate-monotonic ready table: keeps released jobs in arrival order and
// reports the job with the smallest period after every event.
// ----------------------------------------------------------------------------
module rate_monotonic_ready_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Event channel: one transaction carries one scheduling event.
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [rmrt_pkg::KIND_W-1:0]   kind,
	input  wire logic [rmrt_pkg::TASK_W-1:0]   task_id,
	input  wire logic [rmrt_pkg::TIME_W-1:0]   job_time,
	input  wire logic [rmrt_pkg::TIME_W-1:0]   job_period,
	input  wire logic [rmrt_pkg::TIME_W-1:0]   run_amount,
	// Result channel: one transaction per event.
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic                               sel_valid,
	output logic [rmrt_pkg::TASK_W-1:0]        sel_task,
	output logic [rmrt_pkg::TIME_W-1:0]        sel_remaining,
	output logic [rmrt_pkg::TIME_W-1:0]        sel_period,
	output logic [rmrt_pkg::COUNT_W-1:0]       done_total,
	output logic [rmrt_pkg::COUNT_W-1:0]       miss_total,
	output logic                               release_dropped
);
	import rmrt_pkg::*;

	// The controller only sequences; all table state lives in the datapath.
	cmd_t  cmd;
	stat_t stat;

	// The controller accepts an event when idle, walks the sweep until the
	// datapath reports that every occupied entry has been visited, and then
	// waits for the result register to be free before publishing.
	rmrt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.stat         (stat)
	);

	// The sweep compacts the table in place: surviving jobs are rewritten at
	// the write pointer, which never overtakes the read pointer, so arrival
	// order is kept. The minimum-period search runs alongside the sweep with
	// a strict comparison, so the earliest-arrived job wins a tie. A release
	// is appended after the sweep and compared against the running best.
	rmrt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.kind            (kind),
		.task_id         (task_id),
		.job_time        (job_time),
		.job_period      (job_period),
		.run_amount      (run_amount),
		.sel_valid       (sel_valid),
		.sel_task        (sel_task),
		.sel_remaining   (sel_remaining),
		.sel_period      (sel_period),
		.done_total      (done_total),
		.miss_total      (miss_total),
		.release_dropped (release_dropped)
	);

endmodule
`default_nettype wire

// File: src/rmrt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmrt_ctrl
// Sequencer for one event: accept, sweep the table entry by entry, then
// publish the result into the output register once it is free.
// ----------------------------------------------------------------------------
module rmrt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	output logic                result_valid,
	input  wire logic           result_ready,
	output rmrt_pkg::cmd_t      cmd,
	input  wire rmrt_pkg::stat_t stat
);
	import rmrt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   slot_free;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;
	assign slot_free    = !res_valid_q || result_ready;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_FINISH;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/rmrt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmrt_datapath
// Job table, compacting sweep, running minimum-period search, counters
// and the result register.
// ----------------------------------------------------------------------------
module rmrt_datapath #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rmrt_pkg::cmd_t                cmd,
	output rmrt_pkg::stat_t                    stat,
	input  wire logic [rmrt_pkg::KIND_W-1:0]   kind,
	input  wire logic [rmrt_pkg::TASK_W-1:0]   task_id,
	input  wire logic [rmrt_pkg::TIME_W-1:0]   job_time,
	input  wire logic [rmrt_pkg::TIME_W-1:0]   job_period,
	input  wire logic [rmrt_pkg::TIME_W-1:0]   run_amount,
	output logic                               sel_valid,
	output logic [rmrt_pkg::TASK_W-1:0]        sel_task,
	output logic [rmrt_pkg::TIME_W-1:0]        sel_remaining,
	output logic [rmrt_pkg::TIME_W-1:0]        sel_period,
	output logic [rmrt_pkg::COUNT_W-1:0]       done_total,
	output logic [rmrt_pkg::COUNT_W-1:0]       miss_total,
	output logic                               release_dropped
);
	import rmrt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		return (c == '1) ? c : c + COUNT_W'(1);
	endfunction

	// Job table; entries below fill_q are occupied, in arrival order.
	logic [TASK_W-1:0] ent_task_q [TABLE_DEPTH];
	logic [TIME_W-1:0] ent_rem_q  [TABLE_DEPTH];
	logic [TIME_W-1:0] ent_per_q  [TABLE_DEPTH];
	logic [CNT_W-1:0]  fill_q, rd_q, wr_q;

	// Latched event.
	kind_t             kind_q;
	logic [TASK_W-1:0] task_q;
	logic [TIME_W-1:0] time_q, per_q, amt_q;
	logic              act_q;

	// Running best among kept entries.
	logic              best_found_q;
	logic [TASK_W-1:0] best_task_q;
	logic [TIME_W-1:0] best_rem_q, best_per_q;

	logic [COUNT_W-1:0] done_q, miss_q;

	// Result register.
	logic               out_valid_q, out_drop_q;
	logic [TASK_W-1:0]  out_task_q;
	logic [TIME_W-1:0]  out_rem_q, out_per_q;
	logic [COUNT_W-1:0] out_done_q, out_miss_q;

	logic [IDX_W-1:0]  rd_idx, wr_idx;
	logic [TASK_W-1:0] cur_task;
	logic [TIME_W-1:0] cur_rem, cur_per, new_rem;
	logic              hit, keep, miss_inc, done_inc, better;
	logic              has_room, append, new_best, dropped;

	assign rd_idx   = rd_q[IDX_W-1:0];
	assign wr_idx   = wr_q[IDX_W-1:0];
	assign cur_task = ent_task_q[rd_idx];
	assign cur_rem  = ent_rem_q[rd_idx];
	assign cur_per  = ent_per_q[rd_idx];

	assign stat.scan_done = (rd_q == fill_q);

	assign hit    = act_q && (kind_q != KIND_RELEASE) && (cur_task == task_q);
	assign better = !best_found_q || (cur_per < best_per_q);

	always_comb begin
		keep     = 1'b1;
		new_rem  = cur_rem;
		miss_inc = 1'b0;
		done_inc = 1'b0;
		if (hit) begin
			case (kind_q)
				KIND_EXPIRE: begin
					keep     = 1'b0;
					miss_inc = (cur_rem != '0);
				end
				KIND_COMPLETE: begin
					keep     = 1'b0;
					done_inc = 1'b1;
				end
				KIND_RUN: begin
					if (cur_rem > amt_q) begin
						new_rem = cur_rem - amt_q;
					end else begin
						keep = 1'b0;
					end
				end
				default: begin
					keep = 1'b1;
				end
			endcase
		end
	end

	// After the sweep wr_q equals the number of surviving jobs.
	assign has_room = (wr_q < CNT_W'(TABLE_DEPTH));
	assign append   = act_q && (kind_q == KIND_RELEASE) && has_room;
	assign dropped  = act_q && (kind_q == KIND_RELEASE) && !has_room;
	assign new_best = append && (!best_found_q || (per_q < best_per_q));

	always_ff @(posedge clk) begin
		if (cmd.step && keep) begin
			ent_task_q[wr_idx] <= cur_task;
			ent_rem_q[wr_idx]  <= new_rem;
			ent_per_q[wr_idx]  <= cur_per;
		end else if (cmd.finish && append) begin
			ent_task_q[wr_idx] <= task_q;
			ent_rem_q[wr_idx]  <= time_q;
			ent_per_q[wr_idx]  <= per_q;
		end
		if (cmd.load) begin
			kind_q <= kind_t'(kind);
			task_q <= task_id;
			time_q <= job_time;
			per_q  <= job_period;
			amt_q  <= run_amount;
		end
		if (cmd.step && keep && better) begin
			best_task_q <= cur_task;
			best_rem_q  <= new_rem;
			best_per_q  <= cur_per;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			rd_q         <= '0;
			wr_q         <= '0;
			act_q        <= 1'b0;
			best_found_q <= 1'b0;
			done_q       <= '0;
			miss_q       <= '0;
			out_valid_q  <= 1'b0;
			out_drop_q   <= 1'b0;
			out_task_q   <= '0;
			out_rem_q    <= '0;
			out_per_q    <= '0;
			out_done_q   <= '0;
			out_miss_q   <= '0;
		end else begin
			if (cmd.load) begin
				rd_q         <= '0;
				wr_q         <= '0;
				best_found_q <= 1'b0;
				act_q        <= (int'(task_id) < MAX_TASKS);
			end
			if (cmd.step) begin
				rd_q <= rd_q + CNT_W'(1);
				if (keep) begin
					wr_q <= wr_q + CNT_W'(1);
					if (better) begin
						best_found_q <= 1'b1;
					end
				end
				if (miss_inc) begin
					miss_q <= sat_inc(miss_q);
				end
				if (done_inc) begin
					done_q <= sat_inc(done_q);
				end
			end
			if (cmd.finish) begin
				fill_q      <= append ? wr_q + CNT_W'(1) : wr_q;
				out_valid_q <= best_found_q || append;
				out_drop_q  <= dropped;
				out_done_q  <= done_q;
				out_miss_q  <= miss_q;
				if (new_best) begin
					out_task_q <= task_q;
					out_rem_q  <= time_q;
					out_per_q  <= per_q;
				end else if (best_found_q) begin
					out_task_q <= best_task_q;
					out_rem_q  <= best_rem_q;
					out_per_q  <= best_per_q;
				end else begin
					out_task_q <= '0;
					out_rem_q  <= '0;
					out_per_q  <= '0;
				end
			end
		end
	end

	assign sel_valid       = out_valid_q;
	assign sel_task        = out_task_q;
	assign sel_remaining   = out_rem_q;
	assign sel_period      = out_per_q;
	assign done_total      = out_done_q;
	assign miss_total      = out_miss_q;
	assign release_dropped = out_drop_q;

endmodule
`default_nettype wire

// File: src/rmrt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmrt_checker
// Port-level checks of the ready table's result channel, bound to the top.
// ----------------------------------------------------------------------------
module rmrt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          result_valid,
	input wire logic                          result_ready,
	input wire logic                          sel_valid,
	input wire logic [rmrt_pkg::TASK_W-1:0]   sel_task,
	input wire logic [rmrt_pkg::TIME_W-1:0]   sel_remaining,
	input wire logic [rmrt_pkg::TIME_W-1:0]   sel_period,
	input wire logic [rmrt_pkg::COUNT_W-1:0]  done_total,
	input wire logic [rmrt_pkg::COUNT_W-1:0]  miss_total,
	input wire logic                          release_dropped
);

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result withdrawn before acceptance");

	// An empty table reports all-zero selection fields.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !sel_valid |->
			(sel_task == '0) && (sel_remaining == '0) && (sel_period == '0))
		else $error("selection fields not zero with empty table");

	// A dropped release means the table is full, so a job is selected.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && release_dropped |-> sel_valid)
		else $error("release dropped while table reports empty");

	// Saturating counters never go backwards.
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (done_total >= $past(done_total)) && (miss_total >= $past(miss_total)))
		else $error("completion or miss count decreased");

endmodule

bind rate_monotonic_ready_table rmrt_checker u_rmrt_checker (.*);
`default_nettype wire
